// ===== rtl/cqr_pkg.sv =====
// cqr_pkg: operation codes, status codes and the command record
// shared by the circular queue front end, command queue and back end
// no dependencies
`default_nettype none

package cqr_pkg;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_INSERT  = 2'd0;
	localparam op_t OP_DROP    = 2'd1;
	localparam op_t OP_READOUT = 2'd2;
	localparam op_t OP_UNUSED  = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	localparam int CMDQ_DEPTH = 2;

	typedef struct packed {
		op_t                kind;
		logic signed [31:0] value;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cqr_if.sv =====
// cqr_if: valid/ready channels of the circular queue
// request channel, result channel and the internal command channel
// depends on cqr_pkg
`default_nettype none

interface cqr_in_if import cqr_pkg::*; ();
	logic               valid;
	logic               ready;
	op_t                op;
	logic signed [31:0] value;

	modport source (output valid, op, value, input ready);
	modport sink (input valid, op, value, output ready);
endinterface

interface cqr_out_if import cqr_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic               has_data;
	logic signed [31:0] data;
	logic               last;

	modport source (output valid, status, has_data, data, last, input ready);
	modport sink (input valid, status, has_data, data, last, output ready);
endinterface

interface cqr_cmd_if import cqr_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t cmd;

	modport source (output valid, cmd, input ready);
	modport sink (input valid, cmd, output ready);
endinterface

`default_nettype wire

// ===== rtl/cqr_front.sv =====
// cqr_front: registers each request and classifies its operation
// unused codes are dropped here, the rest go on as commands
// depends on cqr_pkg, cqr_if
`default_nettype none

module cqr_front import cqr_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	cqr_in_if.sink      req,
	cqr_cmd_if.source   cmd
);

	logic valid_s1;
	cmd_t cmd_s1;

	assign req.ready = !valid_s1 || cmd.ready;
	assign cmd.valid = valid_s1;
	assign cmd.cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid && (req.op != OP_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1.kind  <= req.op;
			cmd_s1.value <= req.value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cqr_cmdq.sv =====
// cqr_cmdq: short command queue between front end and back end
// lets either side stall on its own
// depends on cqr_pkg, cqr_if
`default_nettype none

module cqr_cmdq import cqr_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	cqr_cmd_if.sink     enq,
	cqr_cmd_if.source   deq
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          slot_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          push;
	logic          pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(CMDQ_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign enq.ready = (fill_q != CW'(CMDQ_DEPTH));
	assign deq.valid = (fill_q != '0);
	assign deq.cmd   = slot_q[rd_ptr_q];
	assign push      = enq.valid && enq.ready;
	assign pop       = deq.valid && deq.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= enq.cmd;
	end

endmodule

`default_nettype wire

// ===== rtl/cqr_back.sv =====
// cqr_back: executes commands on the circular entry store
// holds head, tail, count, the store, a read stage and the result register
// depends on cqr_pkg, cqr_if
`default_nettype none

module cqr_back import cqr_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	cqr_cmd_if.sink     cmd,
	cqr_out_if.source   rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic          busy_q;
	logic [IW-1:0] rd_pos_q;
	logic [CW-1:0] rd_left_q;

	logic               valid_s1;
	status_t            status_s1;
	logic               has_s1;
	logic               last_s1;
	logic signed [31:0] rd_data_s1;

	logic               out_valid_q;
	status_t            out_status_q;
	logic               out_has_q;
	logic signed [31:0] out_data_q;
	logic               out_last_q;

	logic          full;
	logic          empty;
	logic          s1_adv;
	logic          can_issue;
	logic          exec;
	logic          stream;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	status_t       iss_status;
	logic          iss_has;
	logic          iss_last;

	function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign can_issue = !valid_s1 || s1_adv;
	assign cmd.ready = !busy_q && can_issue;
	assign exec      = cmd.valid && cmd.ready;
	assign stream    = busy_q && can_issue;
	assign rd_addr   = busy_q ? rd_pos_q : head_q;
	assign rd_en     = stream || (exec && cmd.cmd.kind == OP_READOUT && !empty);

	always_comb begin
		iss_status = ST_OK;
		iss_has    = 1'b0;
		iss_last   = 1'b1;
		if (busy_q) begin
			iss_has  = 1'b1;
			iss_last = (rd_left_q == CW'(1));
		end else begin
			unique case (cmd.cmd.kind)
				OP_INSERT: begin
					if (full) iss_status = ST_OVERFLOW;
				end
				OP_DROP: begin
					if (empty) iss_status = ST_UNDERFLOW;
				end
				OP_READOUT: begin
					if (empty) begin
						iss_status = ST_UNDERFLOW;
					end else begin
						iss_has  = 1'b1;
						iss_last = (count_q == CW'(1));
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			rd_pos_q    <= '0;
			rd_left_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				unique case (cmd.cmd.kind)
					OP_INSERT: begin
						if (!full) begin
							tail_q  <= wrap_next(tail_q);
							count_q <= count_q + CW'(1);
						end
					end
					OP_DROP: begin
						if (!empty) begin
							head_q  <= wrap_next(head_q);
							count_q <= count_q - CW'(1);
						end
					end
					OP_READOUT: begin
						if (count_q > CW'(1)) begin
							busy_q    <= 1'b1;
							rd_pos_q  <= wrap_next(head_q);
							rd_left_q <= count_q - CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (stream) begin
				rd_pos_q  <= wrap_next(rd_pos_q);
				rd_left_q <= rd_left_q - CW'(1);
				if (rd_left_q == CW'(1)) busy_q <= 1'b0;
			end
			if (can_issue) valid_s1 <= exec || stream;
			if (!out_valid_q || rsp.ready) out_valid_q <= valid_s1;
		end
	end

	// entry store, no reset
	always_ff @(posedge clk) begin
		if (exec && cmd.cmd.kind == OP_INSERT && !full) mem[tail_q] <= cmd.cmd.value;
		if (rd_en) rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (exec || stream) begin
			status_s1 <= iss_status;
			has_s1    <= iss_has;
			last_s1   <= iss_last;
		end
		if (s1_adv) begin
			out_status_q <= status_s1;
			out_has_q    <= has_s1;
			out_data_q   <= has_s1 ? rd_data_s1 : '0;
			out_last_q   <= last_s1;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.has_data = out_has_q;
	assign rsp.data     = out_data_q;
	assign rsp.last     = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_stream_left: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rd_left_q != '0) && (rd_left_q < count_q))
		else $error("readout remainder out of range");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_has_q) |-> out_last_q)
		else $error("status-only result without last");

	a_stream_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !stream) |=> (count_q == $past(count_q)))
		else $error("count changed during readout");

endmodule

`default_nettype wire

// ===== rtl/circular_queue_with_readout.sv =====
// path: front-end register, command queue, back-end read stage, result register to rsp
// throughput, while rsp does not stall: one request per cycle for insert and drop; a
// readout of n held entries blocks commands, one entry per cycle from the store port
// reset: head, tail and count cleared, command queue and result register empty;
// the entry store is not cleared and no entry is read before it is written
`default_nettype none

module circular_queue_with_readout import cqr_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	cqr_in_if.sink      req,
	cqr_out_if.source   rsp
);

	cqr_cmd_if front_cmd ();
	cqr_cmd_if back_cmd ();

	cqr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (front_cmd)
	);

	cqr_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (front_cmd),
		.deq    (back_cmd)
	);

	cqr_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (back_cmd),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== tb/circular_queue_with_readout_tb.sv =====
// circular_queue_with_readout_tb: directed and random requests against the circular queue,
// results checked in order against a scoreboard that tracks the queue contents
// depends on cqr_pkg, cqr_if and circular_queue_with_readout
`timescale 1ns / 100ps

module circular_queue_with_readout_tb;
	import cqr_pkg::*;

	localparam int DEPTH = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int END_LIMIT = 20000;

	typedef struct {
		status_t            status;
		logic               has_data;
		logic signed [31:0] data;
		logic               last;
	} queue_result_t;

	class queue_scoreboard_t;
		localparam int SLOTS = DEPTH;
		logic signed [31:0]     store [SLOTS];
		bit [$clog2(SLOTS)-1:0] head_idx;
		bit [$clog2(SLOTS)-1:0] tail_idx;
		bit [$clog2(SLOTS):0]   fill;
		queue_result_t          pending_results [$];
		int errors;
		int n_requests;
		int n_readouts;
		int n_results;
		int n_overflow;
		int n_underflow;

		function bit [$clog2(SLOTS)-1:0] next_slot(bit [$clog2(SLOTS)-1:0] idx);
			return (idx == SLOTS - 1) ? '0 : idx + 1'b1;
		endfunction

		function void push_result(status_t status, logic has_data, logic signed [31:0] data,
				logic last);
			queue_result_t r;
			r.status = status;
			r.has_data = has_data;
			r.data = data;
			r.last = last;
			pending_results.push_back(r);
			if (status == ST_OVERFLOW)
				n_overflow++;
			if (status == ST_UNDERFLOW)
				n_underflow++;
		endfunction

		function void note_request(op_t op, logic signed [31:0] value);
			bit [$clog2(SLOTS)-1:0] pos;
			case (op)
			OP_INSERT: begin
				n_requests++;
				if (fill == SLOTS) begin
					push_result(ST_OVERFLOW, 1'b0, '0, 1'b1);
				end else begin
					store[tail_idx] = value;
					tail_idx = next_slot(tail_idx);
					fill++;
					push_result(ST_OK, 1'b0, '0, 1'b1);
				end
			end
			OP_DROP: begin
				n_requests++;
				if (fill == 0) begin
					push_result(ST_UNDERFLOW, 1'b0, '0, 1'b1);
				end else begin
					head_idx = next_slot(head_idx);
					fill--;
					push_result(ST_OK, 1'b0, '0, 1'b1);
				end
			end
			OP_READOUT: begin
				n_requests++;
				n_readouts++;
				if (fill == 0) begin
					push_result(ST_UNDERFLOW, 1'b0, '0, 1'b1);
				end else begin
					pos = head_idx;
					for (int k = 0; k < fill; k++) begin
						push_result(ST_OK, 1'b1, store[pos], k == fill - 1);
						pos = next_slot(pos);
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void check_result(status_t status, logic has_data, logic signed [31:0] data,
				logic last);
			queue_result_t want;
			n_results++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: status %0d has_data %0b data %0d last %0b",
					$time, status, has_data, data, last);
				return;
			end
			want = pending_results.pop_front();
			if (status !== want.status || has_data !== want.has_data || data !== want.data ||
					last !== want.last) begin
				errors++;
				$display("%0t mismatch: expected status %0d has_data %0b data %0d last %0b",
					$time, want.status, want.has_data, want.data, want.last);
				$display("%0t          actual   status %0d has_data %0b data %0d last %0b",
					$time, status, has_data, data, last);
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cqr_in_if  req_if ();
	cqr_out_if rsp_if ();

	queue_scoreboard_t board = new();

	bit steady;
	bit hold_off_request;
	int hold_left;
	int items_sent;

	circular_queue_with_readout #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready)
			board.note_request(req_if.op, req_if.value);
		if (arst_n && rsp_if.valid && rsp_if.ready)
			board.check_result(rsp_if.status, rsp_if.has_data, rsp_if.data, rsp_if.last);
	end

	// result side: random stalls, none while steady, long hold-off on request
	initial begin
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= 24);
			end
		end
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(15))
		0: return 32'sh8000_0000;
		1: return 32'sh7fff_ffff;
		2: return 32'sh0000_0000;
		3: return 32'shffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	function automatic op_t rand_op();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return OP_INSERT;
		if (r < 75)
			return OP_DROP;
		if (r < 95)
			return OP_READOUT;
		return OP_UNUSED;
	endfunction

	task automatic idle_sender(input int cycles);
		req_if.valid <= 1'b0;
		req_if.op <= op_t'($urandom);
		req_if.value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_request(input op_t op, input logic signed [31:0] value);
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.value <= value;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (op != OP_UNUSED)
			items_sent++;
		while (!steady && $urandom_range(99) < 24)
			idle_sender(1);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_burst();
		int kind;
		int n;
		kind = $urandom_range(99);
		n = $urandom_range(1, DEPTH + 2);
		if (kind < 30)
			repeat (n) send_request(OP_INSERT, rand_word());
		else if (kind < 50)
			repeat (n) send_request(OP_DROP, rand_word());
		else if (kind < 65)
			send_request(OP_READOUT, rand_word());
		else
			repeat (n) send_request(rand_op(), rand_word());
	endtask

	initial begin
		logic signed [31:0] edge_words [7];
		int random_goal;
		int wait_cycles;
		edge_words = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
			32'sh0000_0001, 32'sh5555_5555, 32'shaaaa_aaaa};
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = OP_INSERT;
		req_if.value = '0;
		steady = 1'b0;
		hold_off_request = 1'b0;
		hold_left = 0;
		items_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases, the unused code, then edge values inserted, read out and dropped
		send_request(OP_DROP, rand_word());
		send_request(OP_READOUT, rand_word());
		send_request(OP_UNUSED, rand_word());
		foreach (edge_words[i])
			send_request(OP_INSERT, edge_words[i]);
		send_request(OP_READOUT, rand_word());
		send_request(OP_DROP, rand_word());
		send_request(OP_READOUT, rand_word());
		// fill to full across the wrap, then overflow and a full readout
		repeat (DEPTH - 6) send_request(OP_INSERT, rand_word());
		send_request(OP_INSERT, rand_word());
		send_request(OP_READOUT, rand_word());
		wait_drained();

		random_goal = items_sent + 300;
		while (items_sent < random_goal - 200)
			random_burst();

		// result side held off while requests keep coming
		hold_off_request = 1'b1;
		repeat (40)
			send_request(($urandom_range(3) == 0) ? OP_READOUT : OP_INSERT, rand_word());
		wait_drained();

		steady = 1'b1;
		while (items_sent < random_goal - 100)
			random_burst();
		steady = 1'b0;
		while (items_sent < random_goal)
			random_burst();

		req_if.valid <= 1'b0;
		@(posedge clk);
		wait_cycles = 0;
		while (board.outstanding() != 0 && wait_cycles < END_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.outstanding() != 0) begin
			board.errors++;
			$display("%0t %0d expected results never arrived", $time, board.outstanding());
		end
		$display("tb: %0d requests (%0d readouts), %0d results, %0d overflow, %0d underflow",
			board.n_requests, board.n_readouts, board.n_results, board.n_overflow,
			board.n_underflow);
		$display("tb: included a %0d-cycle result hold-off and a stretch without idling",
			HOLD_CYCLES);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
